[rtl/taspg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// taspg_pkg
// Shared constants and helpers for the three-axis step pulse generator.
// ----------------------------------------------------------------------------
package taspg_pkg;

	localparam int AXES    = 3;   // lanes that are processed, 1..LANES
	localparam int LANES   = 3;   // lanes carried on the ports
	localparam int SPEED_W = 11;
	localparam int COUNT_W = 5;

	localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(1000);

	// (x / 100) == (x * 41) >> 12 for all x below 1000
	localparam int DIV_RECIP = 41;
	localparam int DIV_SHIFT = 12;
	localparam int PROD_W    = 17;

	// Period reload for a speed magnitude: (1000 - mag) / 100, 0 at or above 1000.
	function automatic logic [COUNT_W-1:0] reload_value(input logic [SPEED_W-1:0] mag);
		logic [SPEED_W-1:0] rem;
		logic [PROD_W-1:0]  prod;
		rem  = SPEED_MAX - mag;
		prod = PROD_W'(rem) * PROD_W'(DIV_RECIP);
		if (mag >= SPEED_MAX) begin
			return '0;
		end
		return COUNT_W'(prod >> DIV_SHIFT);
	endfunction

endpackage

`default_nettype wire

[rtl/taspg_tick_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// taspg_tick_if
// Input channel: one timer tick with three axis speeds and limit levels.
// ----------------------------------------------------------------------------
interface taspg_tick_if;
	import taspg_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [SPEED_W-1:0] speed_x;
	logic signed [SPEED_W-1:0] speed_y;
	logic signed [SPEED_W-1:0] speed_z;
	logic                      limit_level_x;
	logic                      limit_level_y;
	logic                      limit_level_z;

	modport source (
		output valid, speed_x, speed_y, speed_z,
		output limit_level_x, limit_level_y, limit_level_z,
		input  ready
	);

	modport sink (
		input  valid, speed_x, speed_y, speed_z,
		input  limit_level_x, limit_level_y, limit_level_z,
		output ready
	);

endinterface

`default_nettype wire

[rtl/taspg_pins_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// taspg_pins_if
// Output channel: step, direction and driver enable levels after one tick.
// ----------------------------------------------------------------------------
interface taspg_pins_if;

	logic valid;
	logic ready;
	logic step_out_x;
	logic step_out_y;
	logic step_out_z;
	logic dir_out_x;
	logic dir_out_y;
	logic dir_out_z;
	logic driver_enable_n;

	modport source (
		output valid, step_out_x, step_out_y, step_out_z,
		output dir_out_x, dir_out_y, dir_out_z, driver_enable_n,
		input  ready
	);

	modport sink (
		input  valid, step_out_x, step_out_y, step_out_z,
		input  dir_out_x, dir_out_y, dir_out_z, driver_enable_n,
		output ready
	);

endinterface

`default_nettype wire

[rtl/taspg_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// taspg_lane
// One axis: stop test, limit clear, direction, pulse timer, limit latch.
// ----------------------------------------------------------------------------
module taspg_lane (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire logic signed [taspg_pkg::SPEED_W-1:0] speed,
	input  wire logic                                level,
	output logic                                     step,
	output logic                                     dir
);
	import taspg_pkg::*;

	typedef enum logic [1:0] {
		BLK_NONE = 2'b00,
		BLK_POS  = 2'b01,
		BLK_NEG  = 2'b10
	} blk_t;

	logic [COUNT_W-1:0] count_q, count_d;
	blk_t               blk_q, blk_d;
	logic               toggle_q, toggle_d;
	logic               step_q, step_d;
	logic               dir_q, dir_d;

	logic               neg, pos, moving;
	logic [SPEED_W-1:0] mag;

	assign neg = speed[SPEED_W-1];
	assign pos = !neg && (speed != '0);
	assign mag = neg ? (~speed + SPEED_W'(1)) : speed;
	assign moving = (speed != '0) && !(blk_q == BLK_POS && pos) && !(blk_q == BLK_NEG && neg);

	always_comb begin
		count_d  = count_q;
		blk_d    = blk_q;
		toggle_d = toggle_q;
		step_d   = step_q;
		dir_d    = dir_q;
		if (!moving) begin
			count_d = '0;
		end else begin
			if (level) begin
				blk_d = BLK_NONE;
			end
			dir_d = pos;
			if (count_q <= COUNT_W'(1)) begin
				count_d  = reload_value(mag);
				step_d   = toggle_q;
				toggle_d = !toggle_q;
			end else begin
				count_d = count_q - COUNT_W'(1);
			end
			// a pressed switch blocks the direction we are moving in
			if (blk_d == BLK_NONE && !level) begin
				blk_d = pos ? BLK_POS : BLK_NEG;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			blk_q    <= BLK_NONE;
			toggle_q <= 1'b0;
			step_q   <= 1'b0;
			dir_q    <= 1'b0;
		end else if (en) begin
			count_q  <= count_d;
			blk_q    <= blk_d;
			toggle_q <= toggle_d;
			step_q   <= step_d;
			dir_q    <= dir_d;
		end
	end

	assign step = step_q;
	assign dir  = dir_q;

endmodule

`default_nettype wire

[rtl/three_axis_step_pulse_generator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// three_axis_step_pulse_generator_top
// Per-tick step/direction generator for three axes with limit switch blocking.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | handshake
//  --------+-----+-------------------------------------------+-------------
//  tick    | in  | speed_x/y/z (s11), limit_level_x/y/z      | valid/ready
//  pins    | out | step_out_x/y/z, dir_out_x/y/z, drv_en_n   | valid/ready
//
//  One beat per cycle sustained while pins.ready stays high. A tick beat
//  lands in the input register (_s1); when the result slot is free, the
//  lane logic updates its state and the result register, which offers the
//  result on pins.
//  arst_n clears all lane state and both valid flags; payload is not reset.
//  A stalled result holds the input register, and tick.ready drops only
//  when both the input register and the result register are full.
// ----------------------------------------------------------------------------
module three_axis_step_pulse_generator_top (
	input  wire logic     clk,
	input  wire logic     arst_n,
	taspg_tick_if.sink    tick,
	taspg_pins_if.source  pins
);
	import taspg_pkg::*;

	// input register
	logic                      valid_s1;
	logic signed [SPEED_W-1:0] speed_s1 [LANES];
	logic [LANES-1:0]          level_s1;

	// result register; lane state doubles as the pin payload
	logic                      out_valid_q;
	logic                      drv_en_n_q;
	logic [LANES-1:0]          step_lane;
	logic [LANES-1:0]          dir_lane;

	logic                      out_free;
	logic                      adv;

	// result slot is free when empty or being drained this cycle
	assign out_free   = !out_valid_q || pins.ready;
	assign adv        = valid_s1 && out_free;
	assign tick.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			speed_s1[0] <= tick.speed_x;
			speed_s1[1] <= tick.speed_y;
			speed_s1[2] <= tick.speed_z;
			level_s1    <= {tick.limit_level_z, tick.limit_level_y, tick.limit_level_x};
		end
	end

	// axis lanes; lanes past AXES get no lane and are tied to 0
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		if (i < AXES) begin : g_on
			taspg_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.speed  (speed_s1[i]),
				.level  (level_s1[i]),
				.step   (step_lane[i]),
				.dir    (dir_lane[i])
			);
		end else begin : g_off
			assign step_lane[i] = 1'b0;
			assign dir_lane[i]  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (pins.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// driver enable looks at all three speeds, processed or not
	always_ff @(posedge clk) begin
		if (adv) begin
			drv_en_n_q <= (speed_s1[0] == '0) && (speed_s1[1] == '0) && (speed_s1[2] == '0);
		end
	end

	assign pins.valid           = out_valid_q;
	assign pins.step_out_x      = step_lane[0];
	assign pins.step_out_y      = step_lane[1];
	assign pins.step_out_z      = step_lane[2];
	assign pins.dir_out_x       = dir_lane[0];
	assign pins.dir_out_y       = dir_lane[1];
	assign pins.dir_out_z       = dir_lane[2];
	assign pins.driver_enable_n = drv_en_n_q;

`ifndef ASSERT_OFF
	// a tick moved into the lanes always shows up as a result next cycle
	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> pins.valid)
		else $error("advanced tick produced no result");

	// a full input register that cannot drain must stall the tick side
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |-> !tick.ready)
		else $error("tick accepted over an unmoved beat");

	// pin levels change only when a tick is processed
	a_pins_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(step_lane) && $stable(dir_lane))
		else $error("pin levels changed without a tick");
`endif

endmodule

`default_nettype wire

[sim/three_axis_step_pulse_generator_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// three_axis_step_pulse_generator_checker
// Watches the tick and pins channels. It keeps its own copy of the per-axis
// step state and predicts the pin levels for each accepted tick. Each pins
// beat is compared bit by bit, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module three_axis_step_pulse_generator_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	taspg_tick_if     tick,
	taspg_pins_if     pins,
	output int        fail_count,
	output int        pending,
	output int        checked,
	output int        expiry_count,
	output int        latch_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import taspg_pkg::*;

	localparam int FULL_SPEED  = 1000;
	localparam int RELOAD_STEP = 100;

	typedef enum logic [1:0] {BLOCK_NONE, BLOCK_POS, BLOCK_NEG} block_t;

	// bit 0 enable_n, bits 3:1 dir z..x, bits 6:4 step z..x
	typedef struct packed {
		logic [LANES-1:0] step;
		logic [LANES-1:0] dir;
		logic             enable_n;
	} pin_levels_t;

	pin_levels_t        pin_levels_q[$];
	pin_levels_t        seen_levels;
	pin_levels_t        want_levels;

	logic [COUNT_W-1:0] axis_count  [LANES];
	block_t             axis_block  [LANES];
	logic               axis_toggle [LANES];
	logic               axis_step   [LANES];
	logic               axis_dir    [LANES];

	// order per axis: stop test, limit clear, direction, pulse, latch
	task automatic advance_axis(input int a, input int spd, input logic released);
		int mag;
		if (spd == 0 || (axis_block[a] == BLOCK_POS && spd > 0) ||
				(axis_block[a] == BLOCK_NEG && spd < 0)) begin
			axis_count[a] = '0;
			return;
		end
		if (released) begin
			axis_block[a] = BLOCK_NONE;
		end
		axis_dir[a] = (spd > 0);
		if (axis_count[a] <= 1) begin
			mag = (spd < 0) ? -spd : spd;
			axis_count[a] = (mag >= FULL_SPEED) ? '0 : COUNT_W'((FULL_SPEED - mag) / RELOAD_STEP);
			axis_step[a] = axis_toggle[a];
			axis_toggle[a] = ~axis_toggle[a];
			expiry_count++;
		end else begin
			axis_count[a] = axis_count[a] - 1'b1;
		end
		if (axis_block[a] == BLOCK_NONE && !released) begin
			axis_block[a] = (spd > 0) ? BLOCK_POS : BLOCK_NEG;
			latch_count++;
		end
	endtask

	task automatic predict_pins(output pin_levels_t want);
		logic [LANES-1:0][SPEED_W-1:0] speeds;
		logic [LANES-1:0]              released;
		logic                          moving;
		speeds   = {tick.speed_z, tick.speed_y, tick.speed_x};
		released = {tick.limit_level_z, tick.limit_level_y, tick.limit_level_x};
		moving   = 1'b0;
		want     = '0;
		for (int a = 0; a < LANES; a++) begin
			if (speeds[a] != '0) begin
				moving = 1'b1;
			end
		end
		for (int a = 0; a < AXES && a < LANES; a++) begin
			advance_axis(a, int'($signed(speeds[a])), released[a]);
			want.step[a] = axis_step[a];
			want.dir[a]  = axis_dir[a];
		end
		want.enable_n = ~moving;
	endtask

	task automatic compare_pins(input pin_levels_t want, input pin_levels_t seen);
		logic [6:0] w;
		logic [6:0] s;
		string      pin_name [7];
		pin_name = '{"driver_enable_n", "dir_out_x", "dir_out_y", "dir_out_z",
			"step_out_x", "step_out_y", "step_out_z"};
		w = want;
		s = seen;
		for (int b = 0; b < 7; b++) begin
			if (w[b] !== s[b]) begin
				fail_count++;
				$display("%0t: %s expected %0b actual %0b", $time, pin_name[b], w[b], s[b]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < LANES; a++) begin
				axis_count[a]  = '0;
				axis_block[a]  = BLOCK_NONE;
				axis_toggle[a] = 1'b0;
				axis_step[a]   = 1'b0;
				axis_dir[a]    = 1'b0;
			end
			pin_levels_q.delete();
			pending <= 0;
		end else begin
			if (pins.valid && pins.ready) begin
				seen_levels = {pins.step_out_z, pins.step_out_y, pins.step_out_x,
					pins.dir_out_z, pins.dir_out_y, pins.dir_out_x, pins.driver_enable_n};
				if (pin_levels_q.size() == 0) begin
					fail_count++;
					$display("%0t: pins beat expected none actual %b", $time, seen_levels);
				end else begin
					want_levels = pin_levels_q.pop_front();
					compare_pins(want_levels, seen_levels);
					checked++;
				end
			end
			if (tick.valid && tick.ready) begin
				predict_pins(want_levels);
				pin_levels_q.push_back(want_levels);
			end
			pending <= pin_levels_q.size();
		end
	end

	initial begin
		fail_count   = 0;
		checked      = 0;
		expiry_count = 0;
		latch_count  = 0;
	end

endmodule

`default_nettype wire

[sim/three_axis_step_pulse_generator_top_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// three_axis_step_pulse_generator_top_tb
// Drives timer ticks into the step pulse generator with random gaps and
// random pins-side stalls. A checker beside the block predicts every pins
// beat. Directed ticks cover saturation, limit latching and release; then
// held-speed segments with random limit presses and sign flips, mixed with
// raw noise ticks.
// ----------------------------------------------------------------------------
module three_axis_step_pulse_generator_top_tb;
	import taspg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  CLK_PERIOD   = 10;
	localparam int  RANDOM_TICKS = 450;
	localparam int  TAIL_CYCLES  = 8;
	localparam int  DRAIN_LIMIT  = 20000;

	logic clk = 1'b0;
	logic arst_n;
	logic no_idle;                        // both sides run flat out while set
	int   ticks_sent;
	int   ready_run;

	int   fail_count;
	int   pending;
	int   checked;
	int   expiry_count;
	int   latch_count;

	taspg_tick_if tick_ch ();
	taspg_pins_if pins_ch ();

	three_axis_step_pulse_generator_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.pins   (pins_ch)
	);

	three_axis_step_pulse_generator_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (tick_ch),
		.pins         (pins_ch),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked),
		.expiry_count (expiry_count),
		.latch_count  (latch_count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Gap or stall length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Speeds: some stops, some raw 11-bit values past +-1000, many near the
	// top end (short periods), the rest spread over the full range.
	function automatic int pick_speed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			return 0;
		end
		if (r < 14) begin
			return $urandom_range(0, 2047) - 1024;
		end
		if (r < 32) begin
			return $urandom_range(0, 1) ? $urandom_range(900, 1000) : -$urandom_range(900, 1000);
		end
		return $urandom_range(0, 2000) - 1000;
	endfunction

	// Pins side ready: alternates runs of high and stalls. A stall is picked
	// from the same short/long mix as the sender gaps.
	always @(negedge clk) begin
		if (no_idle) begin
			pins_ch.ready <= 1'b1;
			ready_run = 0;
		end else if (ready_run > 0) begin
			ready_run = ready_run - 1;
		end else if (pins_ch.ready) begin
			ready_run = pick_gap();
			if (ready_run > 0) begin
				pins_ch.ready <= 1'b0;
				ready_run = ready_run - 1;
			end
		end else begin
			pins_ch.ready <= 1'b1;
			ready_run = $urandom_range(0, 15);
		end
	end

	// One tick beat. valid only drops when a gap is taken, so back-to-back
	// beats keep it high without a low/high pair in the same step.
	task automatic send_tick(input int sx, input int sy, input int sz,
			input logic [2:0] released);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_ch.valid         <= 1'b1;
		tick_ch.speed_x       <= SPEED_W'(sx);
		tick_ch.speed_y       <= SPEED_W'(sy);
		tick_ch.speed_z       <= SPEED_W'(sz);
		tick_ch.limit_level_x <= released[0];
		tick_ch.limit_level_y <= released[1];
		tick_ch.limit_level_z <= released[2];
		do @(posedge clk); while (!tick_ch.ready);
		ticks_sent++;
	endtask

	// Hold off the sender until every predicted pins beat has come back.
	task automatic drain_pins();
		int waited;
		waited = 0;
		@(negedge clk);
		tick_ch.valid <= 1'b0;
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
	endtask

	initial begin
		int          seg_len;
		int          seg_speed [3];
		logic [2:0]  released;
		logic        drained_mid;

		arst_n                = 1'b0;
		no_idle               = 1'b0;
		ticks_sent            = 0;
		ready_run             = 0;
		drained_mid           = 1'b0;
		tick_ch.valid         = 1'b0;
		tick_ch.speed_x       = '0;
		tick_ch.speed_y       = '0;
		tick_ch.speed_z       = '0;
		tick_ch.limit_level_x = 1'b1;
		tick_ch.limit_level_y = 1'b1;
		tick_ch.limit_level_z = 1'b1;
		pins_ch.ready         = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed ticks. released is {z, y, x}, 0 = switch pressed.
		send_tick(0, 0, 0, 3'b111);              // all stopped, driver off
		send_tick(1000, -1000, 999, 3'b111);     // saturated reload, near top
		send_tick(1000, -1000, 999, 3'b111);
		send_tick(1, -1, 500, 3'b111);           // longest periods
		send_tick(1023, -1024, -1001, 3'b111);   // magnitudes beyond 1000
		send_tick(1023, -1024, -1001, 3'b111);
		send_tick(-999, 950, 1, 3'b111);
		send_tick(500, -500, 700, 3'b000);       // press all: blocks latch
		send_tick(500, -500, 700, 3'b000);       // blocked: counters clear
		send_tick(500, -500, 700, 3'b111);       // released, same way: still blocked
		send_tick(-500, 500, -700, 3'b111);      // reverse and released: clears
		send_tick(-500, 500, -700, 3'b101);      // y latches again
		send_tick(0, 0, 0, 3'b000);              // stopped while pressed
		send_tick(300, -300, 0, 3'b000);         // reverse while still pressed
		send_tick(300, 0, -1, 3'b111);
		repeat (6) send_tick(950, -900, -850, 3'b111);   // watch steps toggle
		drain_pins();

		// Random part: held-speed segments with sporadic presses and sign
		// flips, so blocks latch and later clear; raw noise ticks between.
		while (ticks_sent < RANDOM_TICKS + 21) begin
			if ($urandom_range(0, 99) < 80) begin
				seg_len = $urandom_range(1, 25);
				for (int a = 0; a < 3; a++) begin
					seg_speed[a] = pick_speed();
				end
				for (int k = 0; k < seg_len; k++) begin
					for (int a = 0; a < 3; a++) begin
						if ($urandom_range(0, 99) < 6) begin
							seg_speed[a] = -seg_speed[a];
						end
						released[a] = ($urandom_range(0, 99) >= 8);
					end
					send_tick(seg_speed[0], seg_speed[1], seg_speed[2], released);
				end
			end else begin
				send_tick($urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
					$urandom_range(0, 2047) - 1024, 3'($urandom_range(0, 7)));
			end
			if (!drained_mid && ticks_sent >= 220) begin
				drain_pins();
				drained_mid = 1'b1;
			end
			// one stretch at full rate on both sides
			no_idle = (ticks_sent >= 320 && ticks_sent < 380);
		end
		no_idle = 1'b0;

		drain_pins();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d ticks, checked %0d pins beats", ticks_sent, checked);
		$display("saw %0d step expiries and %0d limit latches", expiry_count, latch_count);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#3_000_000;
		$display("timeout with %0d beats outstanding", pending);
		$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
